@@ rtl/core/sine_tremolo_gain_unit_assert.svh @@
// assertion macros for the tremolo gain unit checker
// expects clk and arst_n in the scope where a macro is used
`ifndef SINE_TREMOLO_GAIN_UNIT_ASSERT_SVH
`define SINE_TREMOLO_GAIN_UNIT_ASSERT_SVH

// checked only outside reset
`define STG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define STG_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/stg_pkg.sv @@
// shared constants, command type and sine rom builder for the tremolo gain unit
// no dependencies
`default_nettype none

package stg_pkg;

	localparam int PHASE_BITS      = 32;
	localparam int SINE_TABLE_BITS = 10;
	localparam int SAMPLE_BITS     = 24;

	localparam int QTR_LEN   = 1 << SINE_TABLE_BITS;
	localparam int ROM_AW    = SINE_TABLE_BITS + 1;
	localparam int Q16_W     = 17;
	localparam int UNITY_Q16 = 65536;

	localparam int INC_W      = 32;
	localparam int DEPTH_W    = 17;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 8;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH = CFG_IDX_W'(1);

	// increment scaling from a 0.32 fraction to the phase width
	localparam int INC_LSH = (PHASE_BITS >= INC_W) ? PHASE_BITS - INC_W : 0;
	localparam int INC_RSH = (PHASE_BITS < INC_W) ? INC_W - PHASE_BITS : 0;
	localparam int INC_WIDE_W = PHASE_BITS + INC_W;

	// shared multiplier: sample magnitude or depth, times gain or depth factor
	localparam int MUL_A_W = (SAMPLE_BITS > DEPTH_W) ? SAMPLE_BITS : DEPTH_W;
	localparam int MUL_B_W = Q16_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int G33_W   = 34;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic [Q16_W-1:0] sine_rom_t [0:QTR_LEN];

	typedef struct packed {
		logic load;
		logic mul_gain;
		logic mul_scale;
		logic finish;
	} dp_cmd_t;

	function automatic logic [63:0] taylor_power(input logic [63:0] term, input logic [63:0] x);
		return (((term * x) >> 30) * x) >> 30;
	endfunction

	// quarter-wave sine in q16, seven-term series in q30, evaluated at elaboration
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] sum;
		for (int k = 0; k <= QTR_LEN; k++) begin
			x    = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
			term = x;
			sum  = x;
			term = taylor_power(term, x) / 64'd6;
			sum  = sum - term;
			term = taylor_power(term, x) / 64'd20;
			sum  = sum + term;
			term = taylor_power(term, x) / 64'd42;
			sum  = sum - term;
			term = taylor_power(term, x) / 64'd72;
			sum  = sum + term;
			term = taylor_power(term, x) / 64'd110;
			sum  = sum - term;
			term = taylor_power(term, x) / 64'd156;
			sum  = sum + term;
			rom[k] = Q16_W'((sum + 64'd8192) >> 14);
		end
		return rom;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/stg_ctrl.sv @@
// sequencer for the tremolo gain unit: input take, two multiplies, output load
// depends on stg_pkg
`default_nettype none

module stg_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output stg_pkg::dp_cmd_t     cmd
);
	import stg_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_GAIN  = 2'd1;
	localparam logic [1:0] ST_SCALE = 2'd2;
	localparam logic [1:0] ST_ROUND = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt     = state_q;
		cmd           = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_GAIN;
				end
			end
			ST_GAIN: begin
				cmd.mul_gain = 1'b1;
				state_nxt    = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.mul_scale = 1'b1;
				state_nxt     = ST_ROUND;
			end
			ST_ROUND: begin
				// hold here until the output slot is free
				if (out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/stg_datapath.sv @@
// datapath: config registers, lfo phase, sine rom, shared multiplier, rounding
// depends on stg_pkg
`default_nettype none

module stg_datapath (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire stg_pkg::dp_cmd_t                      cmd,
	input  wire logic signed [stg_pkg::SAMPLE_BITS-1:0] sample_in,
	output logic signed [stg_pkg::SAMPLE_BITS-1:0]     sample_out,
	input  wire logic                                  cfg_wr_en,
	input  wire logic [stg_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [stg_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import stg_pkg::*;

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	logic [PHASE_BITS-1:0]      phase_q;
	logic [INC_W-1:0]           inc_q;
	logic [DEPTH_W-1:0]         depth_q;
	logic [INC_WIDE_W-1:0]      inc_wide;
	logic [PHASE_BITS-1:0]      inc_scaled;

	logic [1:0]                 quad;
	logic [SINE_TABLE_BITS-1:0] idx;
	logic [ROM_AW-1:0]          rom_addr;
	logic [Q16_W-1:0]           sine_q;
	logic                       sine_neg_q;

	logic [SAMPLE_BITS-1:0]     raw;
	logic [SAMPLE_BITS-1:0]     mag;
	logic [SAMPLE_BITS-1:0]     mag_q;
	logic                       neg_q;

	logic [DEPTH_W-1:0]         depth_sat;
	logic [MUL_B_W-1:0]         gain_m;
	logic [G33_W-1:0]           g33;
	logic [G33_W-1:0]           g33_rnd;
	logic [Q16_W-1:0]           g16;
	logic [MUL_A_W-1:0]         mul_a;
	logic [MUL_B_W-1:0]         mul_b;
	logic [PROD_W-1:0]          prod_q;
	logic [PROD_W-1:0]          prod_rnd;
	logic [SAMPLE_BITS-1:0]     pm;
	logic [SAMPLE_BITS-1:0]     res;
	logic [SAMPLE_BITS-1:0]     out_q;

	// phase increment scaled to the accumulator width
	assign inc_wide   = INC_WIDE_W'(inc_q);
	assign inc_scaled = PHASE_BITS'((inc_wide << INC_LSH) >> INC_RSH);

	// quadrant select and mirrored table index
	assign quad     = phase_q[PHASE_BITS-1 -: 2];
	assign idx      = phase_q[PHASE_BITS-3 -: SINE_TABLE_BITS];
	assign rom_addr = quad[0] ? (ROM_AW'(QTR_LEN) - ROM_AW'(idx)) : ROM_AW'(idx);

	always_ff @(posedge clk) begin
		sine_q     <= SINE_ROM[rom_addr];
		sine_neg_q <= quad[1];
	end

	assign raw = $unsigned(sample_in);
	assign mag = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= mag;
			neg_q <= raw[SAMPLE_BITS-1];
		end
	end

	// g33 = 2^33 - depth*(1 - sin), first pass forms depth*(1 - sin)
	assign depth_sat = (depth_q > DEPTH_W'(UNITY_Q16)) ? DEPTH_W'(UNITY_Q16) : depth_q;
	assign gain_m    = sine_neg_q ? (MUL_B_W'(UNITY_Q16) + MUL_B_W'(sine_q))
	                              : (MUL_B_W'(UNITY_Q16) - MUL_B_W'(sine_q));
	assign g33       = (G33_W'(1) << 33) - prod_q[G33_W-1:0];
	assign g33_rnd   = g33 + G33_W'(UNITY_Q16);
	assign g16       = g33_rnd[G33_W-1:17];

	assign mul_a = cmd.mul_scale ? MUL_A_W'(mag_q) : MUL_A_W'(depth_sat);
	assign mul_b = cmd.mul_scale ? MUL_B_W'(g16) : gain_m;

	always_ff @(posedge clk) begin
		if (cmd.mul_gain || cmd.mul_scale) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
	end

	// round magnitude half up, then restore sign
	assign prod_rnd = prod_q + PROD_W'(UNITY_Q16 / 2);
	assign pm       = prod_rnd[16 +: SAMPLE_BITS];
	assign res      = neg_q ? (~pm + 1'b1) : pm;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q <= res;
		end
	end

	assign sample_out = $signed(out_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			inc_q   <= '0;
			depth_q <= '0;
		end else begin
			if (cmd.finish) begin
				phase_q <= phase_q + inc_scaled;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_PHASE_INC: inc_q   <= cfg_data[INC_W-1:0];
					REG_MOD_DEPTH: depth_q <= cfg_data[DEPTH_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/sine_tremolo_gain_unit.sv @@
// sine lfo tremolo gain: an input transfer is followed by two passes through
// the one shared 24x18 multiplier (depth times 1 - sin, then sample times
// gain) and a rounding step; no new sample is taken until the result loads
// a result waiting on out_stall holds the block in its final step
// reset clears the lfo phase, both config registers and out_valid;
// the sine rom is constant, so there is no clearing pass
`default_nettype none

module sine_tremolo_gain_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [stg_pkg::SAMPLE_BITS-1:0] sample_in,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [stg_pkg::SAMPLE_BITS-1:0]     sample_out,
	input  wire logic                                  cfg_wr_en,
	input  wire logic [stg_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [stg_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import stg_pkg::*;

	dp_cmd_t cmd;

	stg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	stg_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sample_in  (sample_in),
		.sample_out (sample_out),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

endmodule

`default_nettype wire

@@ rtl/core/stg_chk.sv @@
// port-level checker for the tremolo gain unit, bound to the top level
// depends on stg_pkg and sine_tremolo_gain_unit_assert.svh
`default_nettype none

`include "sine_tremolo_gain_unit_assert.svh"

module stg_chk (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  in_valid,
	input wire logic                                  in_stall,
	input wire logic                                  out_valid,
	input wire logic                                  out_stall,
	input wire logic signed [stg_pkg::SAMPLE_BITS-1:0] sample_out
);
	import stg_pkg::*;

	`STG_ASSERT(a_out_valid_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
	`STG_ASSERT(a_out_data_hold, out_valid && out_stall |=> $stable(sample_out), "stalled result changed")
	// one sample at a time: busy right after an input transfer
	`STG_ASSERT(a_busy_after_take, in_valid && !in_stall |=> in_stall, "second sample taken while busy")
	// a fresh result follows a matching input transfer
	`STG_ASSERT(a_result_timing, $rose(out_valid) |-> $past(in_valid && !in_stall, 4), "result without matching input transfer")
	`STG_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid && !in_stall, "not idle in reset")

endmodule

bind sine_tremolo_gain_unit stg_chk u_chk (.*);

`default_nettype wire
